// File: hdl/qws_pkg.sv
// qws_pkg: shared types, constants and record builders for the quoted word splitter.
// No dependencies; used by qws_core, qws_rsp_queue and quoted_word_splitter_top.
`default_nettype none

package qws_pkg;

   // Limits of one line
   localparam int unsigned MAX_WORDS = 64;
   localparam int unsigned MAX_BYTES = 65535;

   // Byte codes
   localparam logic [7:0] QUOTE_DOUBLE    = 8'h22;
   localparam logic [7:0] QUOTE_SINGLE    = 8'h27;
   localparam logic [7:0] SEPARATOR_RESET = 8'd32;

   // Record kinds
   localparam logic KIND_WORD    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [6:0]  count_or_index;
      logic [15:0] word_start;
      logic [15:0] word_length;
      logic        quoted;
      logic        unclosed;
      logic        ended_on_separator;
      logic        rest_valid;
      logic [15:0] rest_offset;
      logic [15:0] rest_length;
      logic        run_end;
   } rsp_type;

   // Up to two records produced by one byte
   typedef struct packed {
      logic [1:0] count;
      rsp_type    rec0;
      rsp_type    rec1;
   } push_type;

   function automatic logic [15:0] span(input logic [15:0] from_pos, input logic [15:0] to_pos);
      span = (to_pos > from_pos) ? (to_pos - from_pos) : 16'd0;
   endfunction

   function automatic rsp_type word_rec(input logic [6:0] idx, input logic [15:0] start,
                                        input logic [15:0] len, input logic q,
                                        input logic unc);
      rsp_type r;
      r = '0;
      r.kind           = KIND_WORD;
      r.count_or_index = idx;
      r.word_start     = start;
      r.word_length    = len;
      r.quoted         = q;
      r.unclosed       = unc;
      word_rec = r;
   endfunction

endpackage

`default_nettype wire

// File: hdl/qws_rsp_queue.sv
// qws_rsp_queue: four-entry result queue taking up to two records per cycle.
// Depends on qws_pkg.
`default_nettype none

module qws_rsp_queue (
   input  wire                clock,
   input  wire                reset,
   input  qws_pkg::push_type  push,
   output logic               has_room,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output qws_pkg::rsp_type   rsp_data
);

   localparam int unsigned DEPTH = 4;
   localparam int unsigned AW    = $clog2(DEPTH);

   qws_pkg::rsp_type entry_ff [DEPTH];
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   // two free slots needed before a byte may be processed
   assign has_room  = (count_ff <= (AW+1)'(DEPTH - 2));

   always_comb begin
      rd_ptr_in = rd_ptr_ff + AW'(pop);
      wr_ptr_in = wr_ptr_ff + AW'(push.count);
      count_in  = count_ff + (AW+1)'(push.count) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.rec0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + AW'(1)] <= push.rec1;
      end
   end

endmodule

`default_nettype wire

// File: hdl/qws_core.sv
// qws_core: input register and per-byte splitter state update.
// Depends on qws_pkg; feeds qws_rsp_queue.
`default_nettype none

module qws_core #(
   parameter int unsigned MAX_WORDS = qws_pkg::MAX_WORDS,
   parameter int unsigned MAX_BYTES = qws_pkg::MAX_BYTES
) (
   input  wire                clock,
   input  wire                reset,
   input  wire  [7:0]         separator,
   input  wire                req_valid,
   output logic               req_ready,
   input  qws_pkg::req_type   req_data,
   input  wire                has_room,
   output qws_pkg::push_type  push
);

   typedef enum logic [2:0] {
      PH_LEAD   = 3'd0,
      PH_UNQ    = 3'd1,
      PH_NEXT   = 3'd2,
      PH_QUOT   = 3'd3,
      PH_AFTERQ = 3'd4,
      PH_DONEQ  = 3'd5,
      PH_DONE   = 3'd6
   } phase_type;

   logic             in_valid_ff, in_valid_in;
   qws_pkg::req_type in_data_ff;
   logic             fire;

   phase_type   phase_ff, phase_in;
   logic [15:0] position_ff, position_in;
   logic [15:0] cur_start_ff, cur_start_in;
   logic [6:0]  words_ff, words_in;
   logic        quote_single_ff, quote_single_in;
   logic [15:0] rem_start_ff, rem_start_in;
   logic        rem_known_ff, rem_known_in;
   logic        sep_end_ff, sep_end_in;

   logic [7:0]       b;
   logic             last;
   logic [15:0]      cur, nxt;
   logic [7:0]       qch;
   logic             do_begin;
   logic             step_v, final_v;
   qws_pkg::rsp_type step_rec, final_rec, sum_rec;
   logic [6:0]       words_step, words_inc;
   phase_type        phase_step;
   logic [15:0]      cs_step, rem_step;
   logic             known_step, sep_end_step, qs_step;
   logic [1:0]       n_rec;

   assign fire      = in_valid_ff && has_room;
   assign req_ready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   // one byte of work
   always_comb begin
      b         = in_data_ff.data_byte;
      last      = in_data_ff.last;
      cur       = position_ff;
      nxt       = (cur < 16'(MAX_BYTES)) ? (cur + 16'd1) : 16'(MAX_BYTES);
      qch       = quote_single_ff ? qws_pkg::QUOTE_SINGLE : qws_pkg::QUOTE_DOUBLE;
      words_inc = words_ff + 7'd1;

      do_begin     = 1'b0;
      step_v       = 1'b0;
      step_rec     = '0;
      phase_step   = phase_ff;
      cs_step      = cur_start_ff;
      rem_step     = rem_start_ff;
      known_step   = rem_known_ff;
      sep_end_step = sep_end_ff;
      qs_step      = quote_single_ff;

      case (phase_ff)
         PH_LEAD: begin
            do_begin = (b != separator);
         end
         PH_UNQ: begin
            if (b == separator) begin
               step_v     = 1'b1;
               step_rec   = qws_pkg::word_rec(words_ff, cur_start_ff,
                                              qws_pkg::span(cur_start_ff, cur), 1'b0, 1'b0);
               rem_step   = nxt;
               known_step = 1'b1;
               if (last) begin
                  sep_end_step = 1'b1;
               end
               phase_step = (words_inc >= 7'(MAX_WORDS)) ? PH_DONE : PH_NEXT;
            end
         end
         PH_NEXT: begin
            do_begin = 1'b1;
         end
         PH_QUOT: begin
            if (b == qch) begin
               step_v     = 1'b1;
               step_rec   = qws_pkg::word_rec(words_ff, cur_start_ff,
                                              qws_pkg::span(cur_start_ff, cur), 1'b1, 1'b0);
               rem_step   = nxt;
               known_step = 1'b1;
               phase_step = (words_inc >= 7'(MAX_WORDS)) ? PH_DONEQ : PH_AFTERQ;
            end
         end
         PH_AFTERQ: begin
            if (b == separator) begin
               rem_step = nxt;
            end else begin
               do_begin = 1'b1;
            end
         end
         PH_DONEQ: begin
            if (b == separator) begin
               rem_step = nxt;
            end else begin
               phase_step = PH_DONE;
            end
         end
         default: begin
            phase_step = PH_DONE;
         end
      endcase

      // start of a word: quote test wins over the separator test
      if (do_begin) begin
         if (b == qws_pkg::QUOTE_DOUBLE || b == qws_pkg::QUOTE_SINGLE) begin
            qs_step    = (b == qws_pkg::QUOTE_SINGLE);
            cs_step    = nxt;
            phase_step = PH_QUOT;
         end else if (b == separator) begin
            step_v     = 1'b1;
            step_rec   = qws_pkg::word_rec(words_ff, cur, 16'd0, 1'b0, 1'b0);
            rem_step   = nxt;
            known_step = 1'b1;
            if (last) begin
               sep_end_step = 1'b1;
            end
            phase_step = (words_inc >= 7'(MAX_WORDS)) ? PH_DONE : PH_NEXT;
         end else begin
            cs_step    = cur;
            phase_step = PH_UNQ;
         end
      end

      words_step = words_ff + 7'(step_v);

      // open word closed by the line end
      final_v   = last && (phase_step == PH_UNQ || phase_step == PH_QUOT);
      final_rec = qws_pkg::word_rec(words_step, cs_step, qws_pkg::span(cs_step, nxt),
                                    (phase_step == PH_QUOT), (phase_step == PH_QUOT));

      sum_rec                    = '0;
      sum_rec.kind               = qws_pkg::KIND_SUMMARY;
      sum_rec.count_or_index     = words_step + 7'(final_v);
      sum_rec.ended_on_separator = sep_end_step;
      sum_rec.rest_valid         = known_step;
      if (known_step) begin
         sum_rec.rest_offset = rem_step;
         sum_rec.rest_length = qws_pkg::span(rem_step, nxt);
      end
      sum_rec.run_end = 1'b1;

      n_rec = 2'(step_v) + 2'(final_v) + 2'(last);

      push       = '0;
      push.count = fire ? n_rec : 2'd0;
      if (step_v) begin
         push.rec0 = step_rec;
      end else if (final_v) begin
         push.rec0 = final_rec;
      end else begin
         push.rec0 = sum_rec;
      end
      push.rec0.run_end = (n_rec == 2'd1);
      push.rec1         = sum_rec;

      // next line state; the summary returns everything to reset values
      if (last) begin
         phase_in        = PH_LEAD;
         position_in     = 16'd0;
         cur_start_in    = 16'd0;
         words_in        = 7'd0;
         quote_single_in = 1'b0;
         rem_start_in    = 16'd0;
         rem_known_in    = 1'b0;
         sep_end_in      = 1'b0;
      end else begin
         phase_in        = phase_step;
         position_in     = nxt;
         cur_start_in    = cs_step;
         words_in        = words_step;
         quote_single_in = qs_step;
         rem_start_in    = rem_step;
         rem_known_in    = known_step;
         sep_end_in      = sep_end_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_LEAD;
         position_ff     <= 16'd0;
         cur_start_ff    <= 16'd0;
         words_ff        <= 7'd0;
         quote_single_ff <= 1'b0;
         rem_start_ff    <= 16'd0;
         rem_known_ff    <= 1'b0;
         sep_end_ff      <= 1'b0;
      end else if (fire) begin
         phase_ff        <= phase_in;
         position_ff     <= position_in;
         cur_start_ff    <= cur_start_in;
         words_ff        <= words_in;
         quote_single_ff <= quote_single_in;
         rem_start_ff    <= rem_start_in;
         rem_known_ff    <= rem_known_in;
         sep_end_ff      <= sep_end_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/quoted_word_splitter_top.sv
// quoted_word_splitter_top: quote-aware word splitter, top level.
// Depends on qws_pkg, qws_core and qws_rsp_queue.
//
// Usage:
//  - req channel (valid/ready) takes one byte of a line per transfer, with
//    last set on the final byte of the line.
//  - rsp channel (valid/ready) returns word records as each word ends, then
//    one summary record on the last byte; run_end marks a byte's final record.
//  - csr_we/csr_wdata write the separator byte; write only while idle.
// Timing:
//  - a byte is registered on transfer and processed once the queue has
//    room for two records; its records then leave through the queue.
//  - one byte per cycle while rsp_ready is high and bytes give at most
//    one record each; a last byte gives up to two, drained one per cycle.
// Reset clears all line state, empties the result queue and sets the
// separator to a space. When the receiver stalls, the four-entry queue
// fills; the input register holds its byte until two slots are free, and
// req_ready drops once that register is also occupied.
`default_nettype none

module quoted_word_splitter_top #(
   parameter int unsigned MAX_WORDS = qws_pkg::MAX_WORDS,
   parameter int unsigned MAX_BYTES = qws_pkg::MAX_BYTES
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  qws_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output qws_pkg::rsp_type   rsp_data,
   input  wire                csr_we,
   input  wire  [7:0]         csr_wdata
);

   logic [7:0]        separator_ff;
   logic [7:0]        separator_in;
   logic              has_room;
   qws_pkg::push_type push;

   // separator register, written directly with no handshake
   assign separator_in = csr_we ? csr_wdata : separator_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         separator_ff <= qws_pkg::SEPARATOR_RESET;
      end else begin
         separator_ff <= separator_in;
      end
   end

   // per-byte state update and record build
   qws_core #(
      .MAX_WORDS (MAX_WORDS),
      .MAX_BYTES (MAX_BYTES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .separator (separator_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .has_room  (has_room),
      .push      (push)
   );

   // result queue between record build and rsp port
   qws_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .has_room  (has_room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: tb/sv/qws_split_checker.sv
// qws_split_checker: watches the req, rsp and csr ports of the quoted word splitter,
// predicts the word and summary records of every byte and compares them in order.
// Depends on qws_pkg for the transfer types, byte codes and line limits.
`timescale 1ns / 100ps

module qws_split_checker (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   input  wire                        req_ready,
   input  qws_pkg::req_type           req_data,
   input  wire                        rsp_valid,
   input  wire                        rsp_ready,
   input  qws_pkg::rsp_type           rsp_data,
   input  wire                        csr_we,
   input  wire  [7:0]                 csr_wdata,
   output int                         mismatch_count,
   output int                         records_pending
);

   typedef enum logic [2:0] {
      SKIP_LEADING,
      IN_PLAIN,
      AFTER_PLAIN,
      IN_QUOTED,
      AFTER_QUOTED,
      LIMIT_AFTER_QUOTED,
      LIMIT_REACHED
   } scan_state_type;

   scan_state_type scan_state;
   logic [7:0]  sep_char;
   logic [15:0] line_pos;
   logic [15:0] word_begin;
   logic [6:0]  word_count;
   logic        single_quote;
   logic [15:0] rest_begin;
   logic        rest_known;
   logic        sep_on_last;

   qws_pkg::rsp_type expected_records[$];
   qws_pkg::rsp_type byte_records[$];
   qws_pkg::rsp_type oldest;
   int               errors = 0;

   function automatic logic [15:0] bytes_between(input logic [15:0] from_pos,
                                                 input logic [15:0] to_pos);
      return (to_pos > from_pos) ? to_pos - from_pos : 16'd0;
   endfunction

   task automatic clear_line();
      scan_state   = SKIP_LEADING;
      line_pos     = '0;
      word_begin   = '0;
      word_count   = '0;
      single_quote = 1'b0;
      rest_begin   = '0;
      rest_known   = 1'b0;
      sep_on_last  = 1'b0;
   endtask

   task automatic emit_word(input logic [15:0] start, input logic [15:0] len,
                            input logic q, input logic unc);
      qws_pkg::rsp_type r;
      r = '0;
      r.kind           = qws_pkg::KIND_WORD;
      r.count_or_index = word_count;
      r.word_start     = start;
      r.word_length    = len;
      r.quoted         = q;
      r.unclosed       = unc;
      byte_records.push_back(r);
      word_count = word_count + 7'd1;
   endtask

   // Separator terminating a word (or an empty word) outside quotes.
   task automatic close_on_separator(input logic [15:0] start, input logic [15:0] len,
                                     input logic [15:0] nxt, input logic last);
      emit_word(start, len, 1'b0, 1'b0);
      rest_begin = nxt;
      rest_known = 1'b1;
      if (last)
         sep_on_last = 1'b1;
      scan_state = (word_count >= qws_pkg::MAX_WORDS) ? LIMIT_REACHED : AFTER_PLAIN;
   endtask

   // First byte of a new word: quote wins over separator here.
   task automatic open_word(input logic [7:0] b, input logic [15:0] cur,
                            input logic [15:0] nxt, input logic last);
      if (b == qws_pkg::QUOTE_DOUBLE || b == qws_pkg::QUOTE_SINGLE) begin
         single_quote = (b == qws_pkg::QUOTE_SINGLE);
         word_begin   = nxt;
         scan_state   = IN_QUOTED;
      end else if (b == sep_char) begin
         close_on_separator(cur, 16'd0, nxt, last);
      end else begin
         word_begin = cur;
         scan_state = IN_PLAIN;
      end
   endtask

   task automatic split_byte(input qws_pkg::req_type item);
      logic [15:0]      cur;
      logic [15:0]      nxt;
      logic [7:0]       close_char;
      qws_pkg::rsp_type r;
      cur        = line_pos;
      nxt        = (cur < qws_pkg::MAX_BYTES) ? cur + 16'd1 : 16'(qws_pkg::MAX_BYTES);
      close_char = single_quote ? qws_pkg::QUOTE_SINGLE : qws_pkg::QUOTE_DOUBLE;
      byte_records.delete();

      case (scan_state)
         SKIP_LEADING: begin
            if (item.data_byte != sep_char)
               open_word(item.data_byte, cur, nxt, item.last);
         end
         IN_PLAIN: begin
            if (item.data_byte == sep_char)
               close_on_separator(word_begin, bytes_between(word_begin, cur), nxt,
                                  item.last);
         end
         AFTER_PLAIN: begin
            open_word(item.data_byte, cur, nxt, item.last);
         end
         IN_QUOTED: begin
            if (item.data_byte == close_char) begin
               emit_word(word_begin, bytes_between(word_begin, cur), 1'b1, 1'b0);
               rest_begin = nxt;
               rest_known = 1'b1;
               scan_state = (word_count >= qws_pkg::MAX_WORDS) ? LIMIT_AFTER_QUOTED
                                                               : AFTER_QUOTED;
            end
         end
         AFTER_QUOTED: begin
            if (item.data_byte == sep_char)
               rest_begin = nxt;
            else
               open_word(item.data_byte, cur, nxt, item.last);
         end
         LIMIT_AFTER_QUOTED: begin
            if (item.data_byte == sep_char)
               rest_begin = nxt;
            else
               scan_state = LIMIT_REACHED;
         end
         default: begin
            scan_state = LIMIT_REACHED;
         end
      endcase

      line_pos = nxt;

      if (item.last) begin
         // open word runs to the line end
         if (scan_state == IN_PLAIN)
            emit_word(word_begin, bytes_between(word_begin, nxt), 1'b0, 1'b0);
         else if (scan_state == IN_QUOTED)
            emit_word(word_begin, bytes_between(word_begin, nxt), 1'b1, 1'b1);
         r = '0;
         r.kind               = qws_pkg::KIND_SUMMARY;
         r.count_or_index     = word_count;
         r.ended_on_separator = sep_on_last;
         r.rest_valid         = rest_known;
         if (rest_known) begin
            r.rest_offset = rest_begin;
            r.rest_length = bytes_between(rest_begin, nxt);
         end
         byte_records.push_back(r);
         clear_line();
      end

      if (byte_records.size() > 0) begin
         r = byte_records.pop_back();
         r.run_end = 1'b1;
         byte_records.push_back(r);
      end
      foreach (byte_records[i])
         expected_records.push_back(byte_records[i]);
   endtask

   task automatic note_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
         errors++;
      end
   endtask

   task automatic compare_record(input qws_pkg::rsp_type want, input qws_pkg::rsp_type got);
      note_field("kind", 16'(want.kind), 16'(got.kind));
      note_field("count_or_index", 16'(want.count_or_index), 16'(got.count_or_index));
      note_field("word_start", want.word_start, got.word_start);
      note_field("word_length", want.word_length, got.word_length);
      note_field("quoted", 16'(want.quoted), 16'(got.quoted));
      note_field("unclosed", 16'(want.unclosed), 16'(got.unclosed));
      note_field("ended_on_separator", 16'(want.ended_on_separator),
                 16'(got.ended_on_separator));
      note_field("rest_valid", 16'(want.rest_valid), 16'(got.rest_valid));
      note_field("rest_offset", want.rest_offset, got.rest_offset);
      note_field("rest_length", want.rest_length, got.rest_length);
      note_field("run_end", 16'(want.run_end), 16'(got.run_end));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_line();
         sep_char = qws_pkg::SEPARATOR_RESET;
         expected_records.delete();
      end else begin
         if (csr_we)
            sep_char = csr_wdata;
         if (rsp_valid && rsp_ready) begin
            if (expected_records.size() == 0) begin
               $display("%0t: record expected none actual %h", $time, rsp_data);
               errors++;
            end else begin
               oldest = expected_records.pop_front();
               compare_record(oldest, rsp_data);
            end
         end
         if (req_valid && req_ready)
            split_byte(req_data);
      end
      records_pending <= expected_records.size();
      mismatch_count  <= errors;
   end

endmodule

// File: tb/sv/quoted_word_splitter_top_tb.sv
// quoted_word_splitter_top_tb: drives lines of bytes into the quoted word splitter
// under several separator settings with random idle on both channels.
// Depends on qws_pkg, quoted_word_splitter_top and qws_split_checker.
`timescale 1ns / 100ps

module quoted_word_splitter_top_tb;

   localparam int QUIET_LIMIT   = 2000;  // cycles without any transfer before giving up
   localparam int DRAIN_CYCLES  = 6;     // byte register plus core stage, with margin
   localparam int PHASE_BYTES   = 40;
   localparam int PHASE_COUNT   = 10;

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   qws_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   qws_pkg::rsp_type rsp_data;
   logic             csr_we    = 1'b0;
   logic [7:0]       csr_wdata = '0;

   int mismatch_count;
   int records_pending;

   // Stimulus knobs, changed per phase
   int         req_idle_max = 0;
   int         rsp_idle_max = 0;
   logic [7:0] separator_now = qws_pkg::SEPARATOR_RESET;

   int         rsp_gap;
   int         rsp_hold = 0;
   int         quiet_cycles = 0;
   logic [7:0] line_bytes[$];

   quoted_word_splitter_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   qws_split_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .records_pending (records_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: after each transfer, ready drops for a random number of cycles.
   // A gap of zero keeps ready high, so back-to-back transfers happen too.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_valid && rsp_ready) begin
         rsp_gap = $urandom_range(0, rsp_idle_max);
         if (rsp_gap > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold  <= rsp_gap;
         end
      end else if (!rsp_ready) begin
         if (rsp_hold <= 1)
            rsp_ready <= 1'b1;
         else
            rsp_hold <= rsp_hold - 1;
      end
   end

   // Watchdog: a run that stops moving is a failure.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Sender: called at a clock edge; optional gap, then hold valid until the transfer.
   // With no gap, valid stays high across items.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int               gap;
      qws_pkg::req_type item;
      gap            = $urandom_range(0, req_idle_max);
      item.data_byte = b;
      item.last      = last;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_line();
      foreach (line_bytes[i])
         send_byte(line_bytes[i], i == line_bytes.size() - 1);
   endtask

   // Wait until every predicted record has come back, then let the core settle
   // (a byte that gives no record may still be in flight).
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (records_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_separator(input logic [7:0] value);
      drain();
      csr_we        <= 1'b1;
      csr_wdata     <= value;
      separator_now = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Any byte that is neither the separator nor a quote
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while (b == separator_now || b == qws_pkg::QUOTE_DOUBLE ||
             b == qws_pkg::QUOTE_SINGLE);
      return b;
   endfunction

   // Content inside quotes: anything but the closing quote, separators often
   function automatic logic [7:0] quoted_byte(input logic [7:0] close_char);
      logic [7:0] b;
      if ($urandom_range(0, 3) == 0 && separator_now != close_char)
         return separator_now;
      do
         b = 8'($urandom_range(0, 255));
      while (b == close_char);
      return b;
   endfunction

   task automatic append_text(input string s);
      for (int i = 0; i < s.len(); i++)
         line_bytes.push_back(s[i]);
   endtask

   task automatic text_line(input string s);
      line_bytes.delete();
      append_text(s);
      send_line();
   endtask

   // Well-formed line: optional leading separators, then plain, quoted and empty
   // words joined by separator runs. Only the final quote may be left open.
   task automatic word_line(input int word_total);
      int         len;
      logic [7:0] q;
      line_bytes.delete();
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 2)) line_bytes.push_back(separator_now);
      for (int w = 0; w < word_total; w++) begin
         case ($urandom_range(0, 9))
            0: begin
               // empty word: separators alone
            end
            1, 2, 3: begin
               q = $urandom_range(0, 1) ? qws_pkg::QUOTE_SINGLE : qws_pkg::QUOTE_DOUBLE;
               line_bytes.push_back(q);
               len = $urandom_range(0, 5);
               repeat (len) line_bytes.push_back(quoted_byte(q));
               if (w < word_total - 1 || $urandom_range(0, 3) != 0)
                  line_bytes.push_back(q);
            end
            default: begin
               len = $urandom_range(1, 6);
               repeat (len) line_bytes.push_back(plain_byte());
            end
         endcase
         if (w < word_total - 1 || $urandom_range(0, 3) == 0)
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 1)
               line_bytes.push_back(separator_now);
      end
      if (line_bytes.size() == 0)
         line_bytes.push_back(separator_now);
      send_line();
   endtask

   // Broken line: separators, quotes and arbitrary bytes in any order
   task automatic noise_line();
      int pick;
      line_bytes.delete();
      repeat ($urandom_range(1, 12)) begin
         pick = $urandom_range(0, 9);
         if (pick < 3)
            line_bytes.push_back(separator_now);
         else if (pick == 3)
            line_bytes.push_back(qws_pkg::QUOTE_DOUBLE);
         else if (pick == 4)
            line_bytes.push_back(qws_pkg::QUOTE_SINGLE);
         else
            line_bytes.push_back(8'($urandom_range(0, 255)));
      end
      send_line();
   endtask

   function automatic int pick_idle();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 3;
         default: return 18;
      endcase
   endfunction

   initial begin
      int phase_start;
      int pick;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed lines at the reset separator (space)
      req_idle_max = 3;
      rsp_idle_max = 3;
      text_line("  ab");            // leading separators skipped, word runs to the end
      text_line("a  b ");           // empty word, line ends on a separator
      text_line("\"x y\"  z");      // quoted word with separators inside and behind it
      text_line("'ab");             // unclosed single quote
      text_line("a \"");            // line ends right after an opening quote
      text_line(" ");               // only a separator: no words
      line_bytes = '{8'h00, 8'hFF, qws_pkg::SEPARATOR_RESET, 8'hFF};
      send_line();                  // byte extremes as word content

      // Word limit: 63 plain words, a quoted 64th, separators skipped behind it,
      // then bytes that add nothing
      line_bytes.delete();
      repeat (63) begin
         line_bytes.push_back("a");
         line_bytes.push_back(qws_pkg::SEPARATOR_RESET);
      end
      append_text("\"q\"  b c");
      send_line();

      // Random phases, each under one separator setting; the extremes come first
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: write_separator(8'd1);
            1: write_separator(8'd255);
            2: write_separator(8'd0);
            3: write_separator(qws_pkg::QUOTE_DOUBLE);
            4: write_separator(qws_pkg::SEPARATOR_RESET);
            default: write_separator(8'($urandom_range(1, 255)));
         endcase
         req_idle_max = pick_idle();
         rsp_idle_max = pick_idle();
         phase_start  = 0;
         while (phase_start < PHASE_BYTES) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
               word_line($urandom_range(63, 70));
            else if (pick < 5)
               noise_line();
            else
               word_line($urandom_range(0, 8));
            phase_start += line_bytes.size();
         end
      end

      drain();
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
